/* hw/rtl/bb3_pkg.sv */
// ============================================================================
// bb3_pkg
// Shared types and constants for the 3x3 RGB box filter core.
// ============================================================================
`default_nettype none

package bb3_pkg;

    // Widths of the item fields
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned COL_OUT_W  = 10;
    localparam int unsigned ROW_OUT_W  = 12;
    localparam int unsigned PIX_W      = 3 * CHAN_W;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned WIDTH_REG_W = 11;
    localparam int unsigned HEIGHT_REG_W = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Frame geometry
    localparam int unsigned MAX_WIDTH_DEFAULT  = 1024;
    localparam int unsigned MAX_HEIGHT         = 4096;
    localparam int unsigned MIN_SIDE           = 3;
    localparam int unsigned IMAGE_WIDTH_RESET  = 640;
    localparam int unsigned IMAGE_HEIGHT_RESET = 480;

    // Divide by nine: floor(x / 9) == (x * 7282) >> 16 for every x below 2296
    localparam int unsigned SUM_W      = 12;
    localparam int unsigned COLSUM_W   = 10;
    localparam int unsigned DIV9_MUL_W = 13;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
    localparam int unsigned DIV9_SHIFT = 16;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    red_out;
        logic [CHAN_W-1:0]    green_out;
        logic [CHAN_W-1:0]    blue_out;
        logic [COL_OUT_W-1:0] col_out;
        logic [ROW_OUT_W-1:0] row_out;
        logic                 frame_last;
    } pixel_out_t;

endpackage : bb3_pkg

`default_nettype wire

/* hw/rtl/box_blur_3x3_rgb_core.sv */
// ============================================================================
// box_blur_3x3_rgb_core
// Streaming 3x3 RGB box filter, one pixel per clock while out_stall is low.
// ============================================================================
//
// Feed pixels in raster order (row 0 first, left to right). For every interior
// pixel (neither first nor last row, neither first nor last column) the core
// gives one item: the truncated mean of the 3x3 neighbourhood for each channel,
// the pixel's column and row, and frame_last on the final interior pixel. The
// item appears once the input that completes its window has been taken; border
// pixels give nothing. The core takes one pixel per clock indefinitely while
// out_stall is low. Each input item passes through B, where the line-store
// read data, the window update and the sum come together, and then C, where
// the sum is divided by nine through a reciprocal multiply. It then sits in
// the output register, from which the result is offered. The two previous
// rows live in one memory of MAX_WIDTH entries, each entry holding the row
// above and the row two above. The memory is read when an item is taken and
// written back as that item leaves B. The window keeps the column sums of
// the last two columns. A write to either geometry register restarts the
// frame at column 0, row 0 (line store and window keep their contents).
// Only the low 11 bits of cfg_data set the width. Widths outside 3..MAX_WIDTH
// and heights outside 3..4096 are clamped. Write the registers only while the
// core is idle.
//
`default_nettype none

module box_blur_3x3_rgb_core
    import bb3_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire pixel_in_t              in_data,

    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      pixel_out_t             out_data
);

    localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
    localparam int unsigned CLAMP_W = 15;
    localparam int unsigned PROD_W  = SUM_W + DIV9_MUL_W;

    localparam int unsigned WIDTH_RESET_CL =
        (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
    localparam logic [COL_W-1:0] COL_LAST_RESET = COL_W'(WIDTH_RESET_CL - 1);
    localparam logic [ROW_W-1:0] ROW_LAST_RESET = ROW_W'(IMAGE_HEIGHT_RESET - 1);

    // Tag that travels with each item through the pipeline
    typedef struct packed {
        logic [COL_OUT_W-1:0] col_out;
        logic [ROW_OUT_W-1:0] row_out;
        logic                 frame_last;
        logic                 produce;
    } tag_t;

    typedef logic [2:0][SUM_W-1:0]    chan_sum_t;
    typedef logic [2:0][COLSUM_W-1:0] chan_colsum_t;

    // ------------------------------------------------------------------
    // Geometry registers and raster counters
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_last_reg, col_last_next;
    logic [ROW_W-1:0] row_last_reg, row_last_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [CLAMP_W-1:0] width_val;
    logic [CLAMP_W-1:0] height_val;

    logic in_accept;
    logic at_col_last;
    logic at_row_last;

    // ------------------------------------------------------------------
    // Pipeline: B = line-store data, window and sum, C = divide, out register
    // ------------------------------------------------------------------
    logic         b_valid_reg;
    tag_t         b_tag_reg;
    logic [PIX_W-1:0] b_pix_reg;
    logic [COL_W-1:0] b_addr_reg;

    logic         c_valid_reg;
    tag_t         c_tag_reg;
    chan_sum_t    c_sum_reg;

    logic         out_valid_reg;
    pixel_out_t   out_data_reg;

    logic advance_out;
    logic advance_c;
    logic b_move;

    // Line store: each entry is {row above, row two above}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] line_rd_reg;

    // Window column sums: older and newer of the two previous columns
    chan_colsum_t colsum_old_reg;
    chan_colsum_t colsum_new_reg;
    chan_colsum_t colsum_in;
    chan_sum_t    win_sum;

    tag_t         a_tag;
    logic [PIX_W-1:0] a_pix;
    logic [COL_W-1:0] col_m1;
    logic [ROW_W-1:0] row_m1;

    logic [PIX_W-1:0] top_pix;
    logic [PIX_W-1:0] mid_pix;

    logic [2:0][CHAN_W-1:0] div_out;
    logic [PROD_W-1:0]      div_prod [3];

    // Ready chain from the output side back to the input
    assign advance_out = !out_valid_reg || !out_stall;
    assign advance_c   = !c_valid_reg || advance_out;
    assign b_move      = b_valid_reg && advance_c;
    assign in_stall    = b_valid_reg && !advance_c;
    assign in_accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Configuration: clamp once on the write and hold the last index
    // ------------------------------------------------------------------
    always_comb
    begin
        width_val  = CLAMP_W'(cfg_data[WIDTH_REG_W-1:0]);
        height_val = CLAMP_W'(cfg_data[HEIGHT_REG_W-1:0]);
        if (width_val < CLAMP_W'(MIN_SIDE))
        begin
            width_val = CLAMP_W'(MIN_SIDE);
        end
        else if (width_val > CLAMP_W'(MAX_WIDTH))
        begin
            width_val = CLAMP_W'(MAX_WIDTH);
        end
        if (height_val < CLAMP_W'(MIN_SIDE))
        begin
            height_val = CLAMP_W'(MIN_SIDE);
        end
        else if (height_val > CLAMP_W'(MAX_HEIGHT))
        begin
            height_val = CLAMP_W'(MAX_HEIGHT);
        end

        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  col_last_next = COL_W'(width_val - CLAMP_W'(1));
                REG_IMAGE_HEIGHT: row_last_next = ROW_W'(height_val - CLAMP_W'(1));
                default:          ;
            endcase
        end
    end

    // Advance the raster position; a register write restarts the frame
    always_comb
    begin
        at_col_last = (col_reg == col_last_reg);
        at_row_last = (row_reg == row_last_reg);
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_write && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT))
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_accept)
        begin
            if (at_col_last)
            begin
                col_next = '0;
                row_next = at_row_last ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Tag of the item being taken: window centre is one up and one left
    always_comb
    begin
        col_m1             = col_reg - COL_W'(1);
        row_m1             = row_reg - ROW_W'(1);
        a_tag.col_out      = COL_OUT_W'(col_m1);
        a_tag.row_out      = ROW_OUT_W'(row_m1);
        a_tag.produce      = (col_reg >= COL_W'(2)) && (row_reg >= ROW_W'(2));
        a_tag.frame_last   = at_col_last && at_row_last;
        a_pix              = {in_data.blue_in, in_data.green_in, in_data.red_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= COL_LAST_RESET;
            row_last_reg <= ROW_LAST_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: read on accept, write back when the item leaves B.
    // Consecutive items touch neighbouring columns, and B holds at most
    // one pending write, so a read never meets a write to its own entry.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            line_rd_reg <= line_mem[col_reg];
        end
        if (b_move)
        begin
            line_mem[b_addr_reg] <= {b_pix_reg, mid_pix};
        end
    end

    assign top_pix = line_rd_reg[PIX_W-1:0];
    assign mid_pix = line_rd_reg[2*PIX_W-1:PIX_W];

    // New column sum and full window sum, per channel
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            colsum_in[k] = COLSUM_W'(top_pix[k*CHAN_W +: CHAN_W])
                         + COLSUM_W'(mid_pix[k*CHAN_W +: CHAN_W])
                         + COLSUM_W'(b_pix_reg[k*CHAN_W +: CHAN_W]);
            win_sum[k]   = SUM_W'(colsum_old_reg[k]) + SUM_W'(colsum_new_reg[k])
                         + SUM_W'(colsum_in[k]);
        end
    end

    // Divide by nine through a reciprocal multiply
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            div_prod[k] = PROD_W'(c_sum_reg[k]) * PROD_W'(DIV9_MUL);
            div_out[k]  = div_prod[k][DIV9_SHIFT +: CHAN_W];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept || b_move)
            begin
                b_valid_reg <= in_accept;
            end
            if (advance_c)
            begin
                c_valid_reg <= b_valid_reg && b_tag_reg.produce;
            end
            if (advance_out)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            b_tag_reg  <= a_tag;
            b_pix_reg  <= a_pix;
            b_addr_reg <= col_reg;
        end
        if (b_move)
        begin
            colsum_old_reg <= colsum_new_reg;
            colsum_new_reg <= colsum_in;
            c_sum_reg      <= win_sum;
            c_tag_reg      <= b_tag_reg;
        end
        if (advance_out && c_valid_reg)
        begin
            out_data_reg.red_out    <= div_out[0];
            out_data_reg.green_out  <= div_out[1];
            out_data_reg.blue_out   <= div_out[2];
            out_data_reg.col_out    <= c_tag_reg.col_out;
            out_data_reg.row_out    <= c_tag_reg.row_out;
            out_data_reg.frame_last <= c_tag_reg.frame_last;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The last pixel of a frame returns the raster position to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && at_col_last && at_row_last) |=> (col_reg == '0 && row_reg == '0))
        else $error("raster counters did not wrap after the last pixel");

    // Results only come from interior rows
    a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.row_out != '0))
        else $error("result carries a border row");

    // The input only stalls while B is occupied and blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (b_valid_reg && c_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    // An item in B was either taken last cycle or already held there
    a_b_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(b_valid_reg) |-> $past(in_accept))
        else $error("B stage filled without an accepted item");

endmodule : box_blur_3x3_rgb_core

`default_nettype wire
